// ===== rtl/core/acmd_pkg.sv =====
// Shared constants and types for the accelerometer affine calibration and motion detect block.
// Used by accel_affine_calibrate_motion_detect; has no dependencies of its own.
`default_nettype none

package acmd_pkg;

   localparam int unsigned Lanes       = 3;
   localparam int unsigned SampleBits  = 16;   // significant bits of a raw sample, 8 to 16
   localparam int unsigned FieldW      = 16;   // width of one raw sample field
   localparam int unsigned DiffW       = FieldW + 1;
   localparam int unsigned CoefW       = 32;   // signed Q4.28 coefficient
   localparam int unsigned ProdW       = DiffW + CoefW;
   localparam int unsigned AccW        = ProdW + 2;
   localparam int unsigned GravW       = 32;
   localparam int unsigned DistW       = 2 * DiffW;
   localparam int unsigned ThreshW     = 16;
   localparam int unsigned ThreshSqW   = 2 * ThreshW;
   localparam int unsigned ThreshReset = 20;
   localparam int unsigned CoefRegs    = 6;
   localparam int unsigned CsrIdxW     = 3;
   localparam int unsigned CsrDataW    = 64;
   localparam int unsigned OffsetW     = Lanes * FieldW;

   typedef enum logic [CsrIdxW-1:0] {
      REG_COL_X_ROWS01   = 3'd0,
      REG_COL_X_ROWS23   = 3'd1,
      REG_COL_Y_ROWS01   = 3'd2,
      REG_COL_Y_ROWS23   = 3'd3,
      REG_COL_Z_ROWS01   = 3'd4,
      REG_COL_Z_ROWS23   = 3'd5,
      REG_AXIS_OFFSETS   = 3'd6,
      REG_MOVE_THRESHOLD = 3'd7
   } csr_reg_type;

   // Status that travels beside the gravity vector; moved sits in the lowest bit.
   typedef struct packed {
      logic saturated;
      logic moved;
   } rsp_flags_type;

endpackage

`default_nettype wire

// ===== rtl/core/accel_affine_calibrate_motion_detect.sv =====
// Top level of the accelerometer affine calibration and motion detect block.
// Depends on acmd_pkg for widths, register indexes and the result flag struct.
//
//   channel  direction  payload
//   req_*    in         tdata: accel_x, accel_y, accel_z (16 bits each)
//   rsp_*    out        tdata: grav_x, grav_y, grav_z (32 bits each); tuser: moved, saturated
//   csr_*    in         csr_index selects a register, csr_data is its new value
//
// A sample can be accepted every cycle while the output is not stalled; each sample passes
// through stage one, stage two and the output register. Stage one subtracts the offsets, stage two
// holds the nine 17x32 products and the motion decision, the output register holds the saturated sums.
// The reference compare (subtract, square, add, compare) is combinational and feeds stage two.
// Stalls back up stage by stage; empty stages keep taking samples while a result waits.
// Reset is synchronous and loads the configuration, valid flags and reference with their defaults (threshold 20).
`default_nettype none

module accel_affine_calibrate_motion_detect (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,   // grav_x [31:0], grav_y [63:32], grav_z [95:64]
   output logic [1:0]       rsp_tuser,   // moved [0], saturated [1]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int unsigned Lanes      = acmd_pkg::Lanes;
   localparam int unsigned SampleBits = acmd_pkg::SampleBits;
   localparam int unsigned FieldW     = acmd_pkg::FieldW;
   localparam int unsigned DiffW      = acmd_pkg::DiffW;
   localparam int unsigned CoefW      = acmd_pkg::CoefW;
   localparam int unsigned ProdW      = acmd_pkg::ProdW;
   localparam int unsigned AccW       = acmd_pkg::AccW;
   localparam int unsigned GravW      = acmd_pkg::GravW;
   localparam int unsigned DistW      = acmd_pkg::DistW;
   localparam int unsigned ThreshW    = acmd_pkg::ThreshW;
   localparam int unsigned ThreshSqW  = acmd_pkg::ThreshSqW;
   localparam int unsigned CoefRegs   = acmd_pkg::CoefRegs;
   localparam int unsigned CsrDataW   = acmd_pkg::CsrDataW;
   localparam int unsigned OffsetW    = acmd_pkg::OffsetW;
   localparam logic [ThreshSqW-1:0] ThreshSqReset =
      ThreshSqW'(acmd_pkg::ThreshReset * acmd_pkg::ThreshReset);

   // Configuration.
   logic [CsrDataW-1:0]  coef_ff [CoefRegs];
   logic [OffsetW-1:0]   offsets_ff;
   logic [ThreshSqW-1:0] thresh_sq_ff;
   logic [ThreshW-1:0]   thresh_in;
   logic [ThreshSqW-1:0] thresh_sq_in;

   // Stage one: raw and offset-corrected sample.
   logic                    a_valid_ff, a_valid_in;
   logic signed [FieldW-1:0] a_raw_ff  [Lanes];
   logic signed [FieldW-1:0] a_raw_in  [Lanes];
   logic signed [DiffW-1:0]  a_diff_ff [Lanes];
   logic signed [DiffW-1:0]  a_diff_in [Lanes];

   // Stage two: products and motion decision.
   logic                    b_valid_ff, b_valid_in;
   logic signed [ProdW-1:0] b_prod_ff [Lanes][Lanes];   // [output column][input row]
   logic signed [ProdW-1:0] b_prod_in [Lanes][Lanes];
   logic                    b_moved_ff, b_moved_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [GravW-1:0]        rsp_grav_ff [Lanes];
   logic [GravW-1:0]        rsp_grav_in [Lanes];
   acmd_pkg::rsp_flags_type rsp_flags_ff, rsp_flags_in;

   // Reference sample.
   logic                     ref_valid_ff, ref_valid_in;
   logic signed [FieldW-1:0] ref_ff [Lanes];
   logic                     ref_load;
   logic [DistW-1:0]         dist_sq;
   logic                     over_thresh;

   logic req_go, a_go, b_go, c_ready, b_ready;
   logic csr_go;

   assign c_ready    = !rsp_valid_ff || rsp_tready;
   assign b_ready    = !b_valid_ff || c_ready;
   assign req_tready = !a_valid_ff || b_ready;
   assign req_go     = req_tvalid && req_tready;
   assign a_go       = a_valid_ff && b_ready;
   assign b_go       = b_valid_ff && c_ready;
   assign csr_ready  = 1'b1;
   assign csr_go     = csr_valid && csr_ready;

   assign thresh_in    = csr_data[ThreshW-1:0];
   assign thresh_sq_in = ThreshSqW'(thresh_in) * ThreshSqW'(thresh_in);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < CoefRegs; r++) begin
            coef_ff[r] <= '0;
         end
         offsets_ff   <= '0;
         thresh_sq_ff <= ThreshSqReset;
      end else if (csr_go) begin
         case (acmd_pkg::csr_reg_type'(csr_index))
            acmd_pkg::REG_COL_X_ROWS01:   coef_ff[0]   <= csr_data;
            acmd_pkg::REG_COL_X_ROWS23:   coef_ff[1]   <= csr_data;
            acmd_pkg::REG_COL_Y_ROWS01:   coef_ff[2]   <= csr_data;
            acmd_pkg::REG_COL_Y_ROWS23:   coef_ff[3]   <= csr_data;
            acmd_pkg::REG_COL_Z_ROWS01:   coef_ff[4]   <= csr_data;
            acmd_pkg::REG_COL_Z_ROWS23:   coef_ff[5]   <= csr_data;
            acmd_pkg::REG_AXIS_OFFSETS:   offsets_ff   <= csr_data[OffsetW-1:0];
            acmd_pkg::REG_MOVE_THRESHOLD: thresh_sq_ff <= thresh_sq_in;
            default: ;
         endcase
      end
   end

   // Stage one: sign-extend from the significant bits and remove the offset.
   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         a_raw_in[i]  = FieldW'(signed'(req_tdata[i*FieldW +: SampleBits]));
         a_diff_in[i] = DiffW'(a_raw_in[i]) - DiffW'(signed'(offsets_ff[i*FieldW +: FieldW]));
      end
   end

   // Stage two: products of the affine matrix and the motion check against the reference.
   always_comb begin
      logic signed [DiffW-1:0] e;
      logic signed [CoefW-1:0] c;
      dist_sq = '0;
      for (int j = 0; j < Lanes; j++) begin
         for (int i = 0; i < Lanes; i++) begin
            c = coef_ff[j*2 + i/2][(i%2)*CoefW +: CoefW];
            b_prod_in[j][i] = ProdW'(a_diff_ff[i]) * ProdW'(c);
         end
      end
      for (int i = 0; i < Lanes; i++) begin
         e = DiffW'(a_raw_ff[i]) - DiffW'(ref_ff[i]);
         dist_sq = dist_sq + $unsigned(DistW'(e) * DistW'(e));
      end
      over_thresh = dist_sq > DistW'(thresh_sq_ff);
      b_moved_in  = ref_valid_ff && over_thresh;
      // The first sample after reset only loads the reference.
      ref_load     = a_go && (!ref_valid_ff || over_thresh);
      ref_valid_in = ref_valid_ff || a_go;
   end

   // Output stage: add up each column with its translation and clip to 32 bits.
   always_comb begin
      logic signed [AccW-1:0] acc;
      logic                   hi, lo;
      rsp_flags_in.moved     = b_moved_ff;
      rsp_flags_in.saturated = 1'b0;
      for (int j = 0; j < Lanes; j++) begin
         acc = AccW'(signed'(coef_ff[j*2 + 1][2*CoefW-1:CoefW]))
             + AccW'(b_prod_ff[j][0]) + AccW'(b_prod_ff[j][1]) + AccW'(b_prod_ff[j][2]);
         hi = !acc[AccW-1] && (|acc[AccW-2:GravW-1]);
         lo = acc[AccW-1] && !(&acc[AccW-2:GravW-1]);
         if (hi) begin
            rsp_grav_in[j] = {1'b0, {(GravW-1){1'b1}}};
         end else if (lo) begin
            rsp_grav_in[j] = {1'b1, {(GravW-1){1'b0}}};
         end else begin
            rsp_grav_in[j] = acc[GravW-1:0];
         end
         rsp_flags_in.saturated = rsp_flags_in.saturated || hi || lo;
      end
   end

   assign a_valid_in   = req_go || (a_valid_ff && !b_ready);
   assign b_valid_in   = a_go || (b_valid_ff && !c_ready);
   assign rsp_valid_in = b_go || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ref_valid_ff <= 1'b0;
         for (int i = 0; i < Lanes; i++) begin
            ref_ff[i] <= '0;
         end
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ref_valid_ff <= ref_valid_in;
         if (ref_load) begin
            for (int i = 0; i < Lanes; i++) begin
               ref_ff[i] <= a_raw_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         a_raw_ff  <= a_raw_in;
         a_diff_ff <= a_diff_in;
      end
      if (a_go) begin
         b_prod_ff  <= b_prod_in;
         b_moved_ff <= b_moved_in;
      end
      if (b_go) begin
         rsp_grav_ff  <= rsp_grav_in;
         rsp_flags_ff <= rsp_flags_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_grav_ff[2], rsp_grav_ff[1], rsp_grav_ff[0]};
   assign rsp_tuser  = rsp_flags_ff;

   // A movement can only be reported once a reference exists.
   a_moved_needs_ref: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flags_ff.moved |-> ref_valid_ff)
      else $error("movement reported without a reference");

   // Once loaded, the reference stays valid until reset.
   a_ref_stays: assert property (@(posedge clock) disable iff (reset)
      ref_valid_ff |=> ref_valid_ff)
      else $error("reference valid dropped");

   // The input side only stalls when every stage holds a word.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> a_valid_ff && b_valid_ff && rsp_valid_ff)
      else $error("input stalled with an empty stage");

   // A clipped word carries at least one component at a rail.
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flags_ff.saturated |->
         (rsp_grav_ff[0] == {1'b0, {(GravW-1){1'b1}}}) ||
         (rsp_grav_ff[0] == {1'b1, {(GravW-1){1'b0}}}) ||
         (rsp_grav_ff[1] == {1'b0, {(GravW-1){1'b1}}}) ||
         (rsp_grav_ff[1] == {1'b1, {(GravW-1){1'b0}}}) ||
         (rsp_grav_ff[2] == {1'b0, {(GravW-1){1'b1}}}) ||
         (rsp_grav_ff[2] == {1'b1, {(GravW-1){1'b0}}}))
      else $error("saturated flag without a clipped component");

endmodule

`default_nettype wire

// ===== dv/accel_affine_calibrate_motion_detect_test.sv =====
// Self-checking testbench for the accelerometer affine calibration and motion detect block.
// Drives raw samples and register writes, predicts gravity vectors and motion flags, and
// compares each result word. Depends on acmd_pkg and accel_affine_calibrate_motion_detect.
`timescale 1ns / 1ps

module accel_affine_calibrate_motion_detect_test;

   localparam int unsigned Lanes       = acmd_pkg::Lanes;
   localparam int unsigned CoefRegs    = acmd_pkg::CoefRegs;
   localparam int unsigned ThreshReset = acmd_pkg::ThreshReset;
   localparam logic [31:0] COEF_ONE = 32'h1000_0000;   // 1.0 in Q4.28

   typedef enum int {
      STYLE_UNITY,
      STYLE_RANDOM,
      STYLE_MAX,
      STYLE_MIN,
      STYLE_SMALL
   } setting_kind_type;

   typedef struct packed {
      logic        saturated;
      logic        moved;
      logic [31:0] grav_z;
      logic [31:0] grav_y;
      logic [31:0] grav_x;
   } gravity_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   // Mirror of the block's configuration and motion reference.
   logic [63:0] coef_reg [CoefRegs];
   logic [47:0] offset_reg;
   logic [15:0] thresh_reg;
   longint      anchor_pos [Lanes];
   bit          anchor_set;

   logic [47:0] pending_samples [$];
   gravity_type gravity_due [$];
   int          failures;
   int          send_gap;
   int          stall_left;
   bit          steady;
   bit          sample_taken;
   int          walk_pos [Lanes];
   gravity_type want;
   acmd_pkg::rsp_flags_type got_flags;

   accel_affine_calibrate_motion_detect DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint coef_of(int col, int row);
      logic [63:0] r;
      r = coef_reg[col * 2 + row / 2];
      if (row % 2 == 1) return longint'($signed(r[63:32]));
      return longint'($signed(r[31:0]));
   endfunction

   // Works out the result of one sample and moves the reference as the block does.
   function automatic gravity_type calibrate(input logic [47:0] word);
      longint      raw [Lanes];
      longint      diff [Lanes];
      longint      acc;
      longint      dist2;
      longint      err;
      longint      limit_sq;
      logic [31:0] lane_out [Lanes];
      gravity_type res;
      res = '0;
      for (int lane = 0; lane < Lanes; lane++) begin
         raw[lane] = longint'($signed(word[lane*16 +: 16]));
         diff[lane] = raw[lane] - longint'($signed(offset_reg[lane*16 +: 16]));
      end
      for (int col = 0; col < Lanes; col++) begin
         acc = coef_of(col, 3);
         for (int lane = 0; lane < Lanes; lane++) acc += diff[lane] * coef_of(col, lane);
         if (acc > 64'sd2147483647) begin
            lane_out[col] = 32'h7FFF_FFFF;
            res.saturated = 1'b1;
         end else if (acc < -64'sd2147483648) begin
            lane_out[col] = 32'h8000_0000;
            res.saturated = 1'b1;
         end else begin
            lane_out[col] = acc[31:0];
         end
      end
      res.grav_x = lane_out[0];
      res.grav_y = lane_out[1];
      res.grav_z = lane_out[2];
      if (!anchor_set) begin
         for (int lane = 0; lane < Lanes; lane++) anchor_pos[lane] = raw[lane];
         anchor_set = 1'b1;
      end else begin
         dist2 = 0;
         limit_sq = longint'(thresh_reg) * longint'(thresh_reg);
         for (int lane = 0; lane < Lanes; lane++) begin
            err = raw[lane] - anchor_pos[lane];
            dist2 += err * err;
         end
         // The comparison is strict: a distance equal to the threshold is no movement.
         if (dist2 > limit_sq) begin
            res.moved = 1'b1;
            for (int lane = 0; lane < Lanes; lane++) anchor_pos[lane] = raw[lane];
         end
      end
      return res;
   endfunction

   function automatic void apply_register(input logic [2:0] idx, input logic [63:0] data);
      case (acmd_pkg::csr_reg_type'(idx))
         acmd_pkg::REG_AXIS_OFFSETS:   offset_reg = data[47:0];
         acmd_pkg::REG_MOVE_THRESHOLD: thresh_reg = data[15:0];
         default:                      coef_reg[idx] = data;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [31:0] small_coef();
      int s;
      s = $urandom_range(0, 2097152);
      return 32'(s - 1048576);
   endfunction

   function automatic logic [15:0] small_offset();
      int s;
      s = $urandom_range(0, 400);
      return 16'(s - 200);
   endfunction

   function automatic logic [63:0] setting_value(setting_kind_type kind,
                                                 acmd_pkg::csr_reg_type r);
      logic [63:0] v;
      int          col;
      col = int'(r) / 2;
      v = {$urandom, $urandom};   // bits above a register's width stay random
      case (r)
         acmd_pkg::REG_AXIS_OFFSETS:
            case (kind)
               STYLE_UNITY, STYLE_SMALL: v[47:0] = {small_offset(), small_offset(), small_offset()};
               STYLE_MAX:                v[47:0] = {3{16'h7FFF}};
               STYLE_MIN:                v[47:0] = {3{16'h8000}};
               default:                  ;
            endcase
         acmd_pkg::REG_MOVE_THRESHOLD:
            case (kind)
               STYLE_UNITY: v[15:0] = 16'($urandom_range(0, 100));
               STYLE_SMALL: v[15:0] = 16'($urandom_range(1, 300));
               STYLE_MAX:   v[15:0] = 16'hFFFF;
               STYLE_MIN:   v[15:0] = 16'h0000;
               default:     ;
            endcase
         default:
            case (kind)
               STYLE_UNITY:
                  if (r[0] == 1'b0) begin
                     v = {(col == 1) ? COEF_ONE : 32'h0, (col == 0) ? COEF_ONE : 32'h0};
                  end else begin
                     v = {small_coef(), (col == 2) ? COEF_ONE : 32'h0};
                  end
               STYLE_MAX:   v = {2{32'h7FFF_FFFF}};
               STYLE_MIN:   v = {2{32'h8000_0000}};
               STYLE_SMALL: v = {small_coef(), small_coef()};
               default:     ;
            endcase
      endcase
      return v;
   endfunction

   // Mostly a random walk around the last sample so that distances straddle the threshold.
   function automatic logic [47:0] next_sample();
      logic [47:0] w;
      int          r;
      int          span;
      int          v;
      span = int'(thresh_reg) * 3 / 4 + 1;
      for (int lane = 0; lane < Lanes; lane++) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            v = walk_pos[lane] + int'($urandom_range(0, 2 * span)) - span;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
         end else if (r < 88) begin
            v = int'($signed(16'($urandom_range(0, 65535))));
         end else begin
            case ($urandom_range(0, 3))
               0:       v = -32768;
               1:       v = 32767;
               2:       v = -1;
               default: v = 0;
            endcase
         end
         walk_pos[lane] = v;
         w[lane*16 +: 16] = v[15:0];
      end
      return w;
   endfunction

   task automatic push_sample(input int x, input int y, input int z);
      pending_samples.push_back({z[15:0], y[15:0], x[15:0]});
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] wanted);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, wanted);
      failures++;
   endtask

   task automatic write_register(input acmd_pkg::csr_reg_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_setting(input setting_kind_type kind);
      acmd_pkg::csr_reg_type r;
      r = r.first();
      do begin
         write_register(r, setting_value(kind, r));
         r = r.next();
      end while (r != r.first());
   endtask

   // Lets every queued sample through and waits until its result word has come back.
   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_tvalid || gravity_due.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Sender: one word per handshake, random gaps between words.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (req_tvalid && !sample_taken) begin
         // Hold the current word until it is taken.
      end else if (send_gap > 0) begin
         send_gap--;
         req_tvalid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
         req_tdata  <= pending_samples.pop_front();
         req_tvalid <= 1'b1;
         send_gap = pick_gap();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         sample_taken <= 1'b0;
      end else begin
         sample_taken <= req_tvalid && req_tready;
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
         if (rsp_tvalid && rsp_tready) begin
            got_flags = rsp_tuser;
            if (gravity_due.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata[31:0], 32'h0);
            end else begin
               want = gravity_due.pop_front();
               if (rsp_tdata[31:0] !== want.grav_x)
                  report_mismatch("grav_x", rsp_tdata[31:0], want.grav_x);
               if (rsp_tdata[63:32] !== want.grav_y)
                  report_mismatch("grav_y", rsp_tdata[63:32], want.grav_y);
               if (rsp_tdata[95:64] !== want.grav_z)
                  report_mismatch("grav_z", rsp_tdata[95:64], want.grav_z);
               if (got_flags.moved !== want.moved)
                  report_mismatch("moved", 32'(got_flags.moved), 32'(want.moved));
               if (got_flags.saturated !== want.saturated)
                  report_mismatch("saturated", 32'(got_flags.saturated), 32'(want.saturated));
            end
         end
         if (req_tvalid && req_tready) gravity_due.push_back(calibrate(req_tdata));
      end
   end

   initial begin
      #5_000_000;
      $display("[accel_affine_calibrate_motion_detect] ERROR");
      $finish;
   end

   initial begin : stimulus
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = acmd_pkg::REG_COL_X_ROWS01;
      csr_data   = '0;
      failures   = 0;
      steady     = 1'b0;
      for (int i = 0; i < CoefRegs; i++) coef_reg[i] = '0;
      offset_reg = '0;
      thresh_reg = 16'(ThreshReset);
      anchor_set = 1'b0;
      for (int lane = 0; lane < Lanes; lane++) begin
         anchor_pos[lane] = 0;
         walk_pos[lane] = 0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: the first sample only loads the reference, then moves exactly at,
      // just past and well past the default threshold.
      push_sample(100, -100, 5);
      push_sample(120, -100, 5);
      push_sample(121, -100, 5);
      push_sample(133, -84, 5);
      push_sample(134, -84, 5);
      push_sample(-32768, -32768, -32768);
      push_sample(32767, 32767, 32767);
      push_sample(32767, 32767, 32767);
      wait_drained();

      // Largest coefficients: clipping in both directions and an exact fit at the top.
      program_setting(STYLE_MAX);
      write_register(acmd_pkg::REG_AXIS_OFFSETS, 64'h0);
      push_sample(0, 0, 0);
      push_sample(1, 0, 0);
      push_sample(-1, -1, -1);
      push_sample(32767, 32767, 32767);
      push_sample(-32768, -32768, -32768);
      push_sample(0, 0, 0);
      wait_drained();

      program_setting(STYLE_MIN);
      push_sample(32767, 32767, 32767);
      push_sample(-32768, -32768, -32768);
      push_sample(-32768, 32767, 0);
      push_sample(0, 0, 0);
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         program_setting(setting_kind_type'(phase % 5));
         steady = (phase % 3 == 1);
         for (int n = 0; n < 140; n++) pending_samples.push_back(next_sample());
         wait_drained();
      end

      if (gravity_due.size() > 0) report_mismatch("words never returned", 32'h0, 32'h0);
      if (failures == 0) begin
         $display("[accel_affine_calibrate_motion_detect] OK");
      end else begin
         $display("[accel_affine_calibrate_motion_detect] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/acmd_pkg.sv
rtl/core/accel_affine_calibrate_motion_detect.sv
dv/accel_affine_calibrate_motion_detect_test.sv
